[hdl/pcd_pkg.sv]
`default_nettype none

package pcd_pkg;

	localparam int NUM_SEG     = 4;
	localparam int BLOCK_LEN   = 128;
	localparam int TAIL_LEN    = 24;
	localparam int MAX_RESULTS = 64;

	localparam int DATA_W     = 16;
	localparam int MASK_W     = 32;
	localparam int MASK_IDX_W = $clog2(MASK_W);
	localparam int BLK_W      = 10;
	localparam int POS_W      = $clog2(BLOCK_LEN);
	localparam int SEG_W      = 3;
	localparam int CNT_W      = $clog2(MAX_RESULTS);
	localparam int TAIL_IDX_W = $clog2(TAIL_LEN);
	localparam int CFG_W      = 3;

	// Segment index value that stands for the tail section.
	localparam logic [SEG_W-1:0] SEG_TAIL = SEG_W'(NUM_SEG);

	// Tail keeps positions 0,1,4,5,8,9,... (bit k is tail position k).
	localparam logic [TAIL_LEN-1:0] TAIL_KEEP = 24'h333333;

	typedef enum logic [CFG_W-1:0] {
		REG_MASK_ONE    = 3'd0,
		REG_MASK_TWO    = 3'd1,
		REG_MASK_THREE  = 3'd2,
		REG_MASK_FOUR   = 3'd3,
		REG_BLOCKS_ONE  = 3'd4,
		REG_BLOCKS_TWO  = 3'd5,
		REG_BLOCKS_THREE = 3'd6,
		REG_BLOCKS_FOUR = 3'd7
	} cfg_reg_t;

	typedef logic [NUM_SEG-1:0][MASK_W-1:0] mask_arr_t;
	typedef logic [NUM_SEG-1:0][BLK_W-1:0]  blocks_arr_t;

	typedef struct packed {
		logic [SEG_W-1:0] seg;
		logic [BLK_W-1:0] blk;
		logic [POS_W-1:0] pos;
	} pos_state_t;

	typedef struct packed {
		logic       keep;
		logic       done;
		logic       brk_next;
		pos_state_t adv;
		pos_state_t nxt;
	} step_t;

endpackage

`default_nettype wire

[hdl/pcd_step.sv]
`default_nettype none

module pcd_step (
	input  var pcd_pkg::pos_state_t  cur,
	input  var pcd_pkg::mask_arr_t   masks,
	input  var pcd_pkg::blocks_arr_t blocks,
	output pcd_pkg::step_t           res
);

	function automatic pcd_pkg::pos_state_t settle_f(
		input pcd_pkg::pos_state_t  st,
		input pcd_pkg::mask_arr_t   m,
		input pcd_pkg::blocks_arr_t bl
	);
		pcd_pkg::pos_state_t r;
		r = st;
		if (r.seg > pcd_pkg::SEG_TAIL) begin
			r.seg = pcd_pkg::SEG_TAIL;
		end
		// Skip empty segments, and one whose block count has been reached.
		for (int i = 0; i < pcd_pkg::NUM_SEG; i++) begin
			if (r.seg == pcd_pkg::SEG_W'(i) &&
			    (bl[i] == '0 || m[i] == '0 || r.blk >= bl[i])) begin
				r.seg = pcd_pkg::SEG_W'(i + 1);
				r.blk = '0;
				r.pos = '0;
			end
		end
		return r;
	endfunction

	function automatic logic kept_f(
		input pcd_pkg::pos_state_t st,
		input pcd_pkg::mask_arr_t  m
	);
		logic k;
		if (st.seg < pcd_pkg::SEG_TAIL) begin
			k = m[st.seg[1:0]][st.pos[pcd_pkg::MASK_IDX_W-1:0]];
		end else if (st.pos < pcd_pkg::POS_W'(pcd_pkg::TAIL_LEN)) begin
			k = pcd_pkg::TAIL_KEEP[st.pos[pcd_pkg::TAIL_IDX_W-1:0]];
		end else begin
			k = 1'b0;
		end
		return k;
	endfunction

	pcd_pkg::pos_state_t settled;
	pcd_pkg::pos_state_t adv;
	pcd_pkg::pos_state_t nxt;
	logic                done;
	logic [pcd_pkg::POS_W-1:0] pos_inc;
	logic [pcd_pkg::BLK_W-1:0] blk_inc;

	assign settled = settle_f(cur, masks, blocks);
	assign pos_inc = settled.pos + pcd_pkg::POS_W'(1);
	assign blk_inc = settled.blk + pcd_pkg::BLK_W'(1);

	always_comb begin
		adv     = settled;
		adv.pos = pos_inc;
		done    = 1'b0;
		if (settled.seg < pcd_pkg::SEG_TAIL) begin
			if ({1'b0, pos_inc} >= (pcd_pkg::POS_W + 1)'(pcd_pkg::BLOCK_LEN) ||
			    pos_inc == '0) begin
				adv.pos = '0;
				adv.blk = blk_inc;
				if (blk_inc >= blocks[settled.seg[1:0]] || blk_inc == '0) begin
					adv.seg = settled.seg + pcd_pkg::SEG_W'(1);
					adv.blk = '0;
				end
			end
		end else if (pos_inc >= pcd_pkg::POS_W'(pcd_pkg::TAIL_LEN) || pos_inc == '0) begin
			adv  = '0;
			done = 1'b1;
		end
	end

	// Look one position ahead so the final result of a transaction is known
	// when it is produced.
	assign nxt = settle_f(adv, masks, blocks);

	assign res.keep     = kept_f(settled, masks);
	assign res.done     = done;
	assign res.brk_next = (nxt.seg < pcd_pkg::SEG_TAIL) || kept_f(nxt, masks);
	assign res.adv      = adv;
	assign res.nxt      = nxt;

endmodule

`default_nettype wire

[hdl/punctured_code_depuncturer_top.sv]
// Depuncturer for a segmented punctured convolutional code frame.
// Input channel (in_valid, in_stall, soft_value): one received soft bit per
// transaction, belonging to the next kept position of the mother-code frame.
// Output channel (out_valid, out_stall, out_value, last_of_run, frame_done):
// one transaction per mother-code position, zero where the position is
// punctured. last_of_run marks the final output caused by an input, and
// frame_done marks the output that fills the last tail position.
// An input that causes k outputs occupies the block while it is taken and
// while the shared position stepper produces its k outputs, walking the frame
// one position per cycle while the output register is free. in_stall stays
// high during that walk. The first output is registered in the run state.
// A stalled receiver holds the output register and pauses the stepper; the
// next input is taken while the final output still waits in that register.
// Configuration (cfg_write, cfg_index, cfg_data) must be written while idle; the block does not enforce this.
// Reset sets all masks to ones, all block counts to zero and the frame
// position to the start of segment one; no clearing pass is needed.
`default_nettype none

module punctured_code_depuncturer_top (
	input  var logic                          clk,
	input  var logic                          arst_n,
	input  var logic                          cfg_write,
	input  var logic [pcd_pkg::CFG_W-1:0]     cfg_index,
	input  var logic [pcd_pkg::MASK_W-1:0]    cfg_data,
	input  var logic                          in_valid,
	output logic                              in_stall,
	input  var logic signed [pcd_pkg::DATA_W-1:0] soft_value,
	output logic                              out_valid,
	input  var logic                          out_stall,
	output logic signed [pcd_pkg::DATA_W-1:0] out_value,
	output logic                              last_of_run,
	output logic                              frame_done
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_RUN  = 2'b10
	} fsm_t;

	fsm_t                           state_q;
	pcd_pkg::mask_arr_t             mask_q;
	pcd_pkg::blocks_arr_t           blocks_q;
	pcd_pkg::pos_state_t            cur_q;
	logic                           placed_q;
	logic [pcd_pkg::CNT_W-1:0]      n_q;
	logic signed [pcd_pkg::DATA_W-1:0] val_q;
	logic                           out_valid_q;
	logic signed [pcd_pkg::DATA_W-1:0] out_value_q;
	logic                           out_last_q;
	logic                           out_done_q;

	pcd_pkg::step_t step;
	logic           out_free;
	logic           fire;
	logic           cut;
	logic           last;
	logic           accept;

	pcd_step u_step (
		.cur    (cur_q),
		.masks  (mask_q),
		.blocks (blocks_q),
		.res    (step)
	);

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign fire     = (state_q == S_RUN) && out_free;
	assign cut      = (n_q == pcd_pkg::CNT_W'(pcd_pkg::MAX_RESULTS - 1));
	assign last     = step.done || cut || ((placed_q || step.keep) && step.brk_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q   <= '1;
			blocks_q <= '0;
		end else if (cfg_write) begin
			unique case (pcd_pkg::cfg_reg_t'(cfg_index))
				pcd_pkg::REG_MASK_ONE:     mask_q[0]   <= cfg_data;
				pcd_pkg::REG_MASK_TWO:     mask_q[1]   <= cfg_data;
				pcd_pkg::REG_MASK_THREE:   mask_q[2]   <= cfg_data;
				pcd_pkg::REG_MASK_FOUR:    mask_q[3]   <= cfg_data;
				pcd_pkg::REG_BLOCKS_ONE:   blocks_q[0] <= cfg_data[pcd_pkg::BLK_W-1:0];
				pcd_pkg::REG_BLOCKS_TWO:   blocks_q[1] <= cfg_data[pcd_pkg::BLK_W-1:0];
				pcd_pkg::REG_BLOCKS_THREE: blocks_q[2] <= cfg_data[pcd_pkg::BLK_W-1:0];
				pcd_pkg::REG_BLOCKS_FOUR:  blocks_q[3] <= cfg_data[pcd_pkg::BLK_W-1:0];
				default:                   mask_q      <= mask_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cur_q    <= '0;
			placed_q <= 1'b0;
			n_q      <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						placed_q <= 1'b0;
						n_q      <= '0;
						state_q  <= S_RUN;
					end
				end
				S_RUN: begin
					if (fire) begin
						// A frame end or a cut leaves the position unsettled.
						cur_q    <= (step.done || cut) ? step.adv : step.nxt;
						placed_q <= placed_q || step.keep;
						n_q      <= n_q + pcd_pkg::CNT_W'(1);
						if (last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= soft_value;
		end
		if (fire) begin
			out_value_q <= step.keep ? val_q : '0;
			out_last_q  <= last;
			out_done_q  <= step.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = out_valid_q;
	assign out_value   = out_value_q;
	assign last_of_run = out_last_q;
	assign frame_done  = out_done_q;

`ifndef SYNTHESIS
	a_end_of_run: assert property (@(posedge clk) disable iff (!arst_n)
		($past(state_q) == S_RUN && state_q == S_IDLE) |-> (out_valid_q && out_last_q))
		else $error("transaction ended without a final output");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_done_q) |-> out_last_q)
		else $error("frame end output not marked as final");

	a_seg_range: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (cur_q.seg <= pcd_pkg::SEG_TAIL))
		else $error("segment index beyond tail");
`endif

endmodule

`default_nettype wire

[verif/tb.sv]
module tb;

	typedef struct {
		logic signed [pcd_pkg::DATA_W-1:0] value;
		logic                              last;
		logic                              done;
	} position_t;

	class position_board;
		logic [pcd_pkg::MASK_W-1:0] masks [pcd_pkg::NUM_SEG];
		logic [pcd_pkg::BLK_W-1:0]  blocks [pcd_pkg::NUM_SEG];
		logic [pcd_pkg::SEG_W-1:0]  seg;
		logic [pcd_pkg::BLK_W-1:0]  blk;
		logic [pcd_pkg::POS_W-1:0]  pos;
		position_t                  pending_positions [$];
		int                         mismatches;

		function new();
			for (int s = 0; s < pcd_pkg::NUM_SEG; s++) begin
				masks[s] = '1;
				blocks[s] = '0;
			end
			seg = '0;
			blk = '0;
			pos = '0;
			mismatches = 0;
		endfunction

		function void set_reg(pcd_pkg::cfg_reg_t idx, logic [pcd_pkg::MASK_W-1:0] val);
			if (idx <= pcd_pkg::REG_MASK_FOUR) begin
				masks[idx[1:0]] = val;
			end else begin
				blocks[idx[1:0]] = val[pcd_pkg::BLK_W-1:0];
			end
		endfunction

		function int outstanding();
			return pending_positions.size();
		endfunction

		// Skips segments that are empty or already used up.
		function void skip_empty();
			if (seg > pcd_pkg::SEG_TAIL)
				seg = pcd_pkg::SEG_TAIL;
			while (seg < pcd_pkg::SEG_TAIL && (blocks[seg[1:0]] == 0 ||
					masks[seg[1:0]] == 0 || blk >= blocks[seg[1:0]])) begin
				seg = seg + 1'b1;
				blk = '0;
				pos = '0;
			end
		endfunction

		function bit position_kept();
			if (seg < pcd_pkg::SEG_TAIL)
				return masks[seg[1:0]][pos[pcd_pkg::MASK_IDX_W-1:0]];
			if (pos >= pcd_pkg::TAIL_LEN)
				return 1'b0;
			return pcd_pkg::TAIL_KEEP[pos[pcd_pkg::TAIL_IDX_W-1:0]];
		endfunction

		// Steps one frame position and reports whether the frame wrapped.
		function bit step_position();
			pos = pos + 1'b1;
			if (seg < pcd_pkg::SEG_TAIL) begin
				if (pos == 0) begin
					blk = blk + 1'b1;
					if (blk >= blocks[seg[1:0]] || blk == 0) begin
						seg = seg + 1'b1;
						blk = '0;
					end
				end
				return 1'b0;
			end
			if (pos >= pcd_pkg::TAIL_LEN || pos == 0) begin
				seg = '0;
				blk = '0;
				pos = '0;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		// Expands one received soft bit into its run of frame positions.
		function void note_input(logic signed [pcd_pkg::DATA_W-1:0] v);
			int        n;
			bit        placed;
			bit        keep;
			bit        done;
			bit        have;
			position_t held;
			position_t cur;
			n = 0;
			placed = 1'b0;
			have = 1'b0;
			while (n < pcd_pkg::MAX_RESULTS) begin
				skip_empty();
				if (placed && (seg < pcd_pkg::SEG_TAIL || position_kept()))
					break;
				keep = !placed && position_kept();
				done = step_position();
				cur.value = keep ? v : '0;
				cur.last = 1'b0;
				cur.done = done;
				if (have)
					pending_positions.push_back(held);
				held = cur;
				have = 1'b1;
				n++;
				if (keep)
					placed = 1'b1;
				if (done)
					break;
			end
			held.last = 1'b1;
			pending_positions.push_back(held);
		endfunction

		function void check_result(logic signed [pcd_pkg::DATA_W-1:0] v, logic l, logic d);
			position_t e;
			if (pending_positions.size() == 0) begin
				$display("%0t: unexpected output transaction, out_value %0d", $time, v);
				mismatches++;
				return;
			end
			e = pending_positions.pop_front();
			if (v !== e.value) begin
				$display("%0t: out_value expected %0d, actual %0d", $time, e.value, v);
				mismatches++;
			end
			if (l !== e.last) begin
				$display("%0t: last_of_run expected %0b, actual %0b", $time, e.last, l);
				mismatches++;
			end
			if (d !== e.done) begin
				$display("%0t: frame_done expected %0b, actual %0b", $time, e.done, d);
				mismatches++;
			end
		endfunction
	endclass

	logic                              clk = 1'b0;
	logic                              arst_n;
	logic                              cfg_write;
	logic [pcd_pkg::CFG_W-1:0]         cfg_index;
	logic [pcd_pkg::MASK_W-1:0]        cfg_data;
	logic                              in_valid;
	logic                              in_stall;
	logic signed [pcd_pkg::DATA_W-1:0] soft_value;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic signed [pcd_pkg::DATA_W-1:0] out_value;
	logic                              last_of_run;
	logic                              frame_done;

	position_board board = new();
	logic [pcd_pkg::MASK_W-1:0] next_mask [pcd_pkg::NUM_SEG];
	logic [pcd_pkg::BLK_W-1:0]  next_blocks [pcd_pkg::NUM_SEG];
	logic              rx_hold = 1'b0;
	logic              rx_quiet = 1'b0;
	bit                tx_quiet = 1'b0;
	int                rx_gap = 0;

	punctured_code_depuncturer_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.soft_value  (soft_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_value   (out_value),
		.last_of_run (last_of_run),
		.frame_done  (frame_done)
	);

	always #5 clk = ~clk;

	// Receiver: after each transaction it draws how long to hold off.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				board.check_result(out_value, last_of_run, frame_done);
				rx_gap = rx_quiet ? 0 : $urandom_range(0, 15);
			end else if (rx_gap > 0) begin
				rx_gap = rx_gap - 1;
			end
		end
		out_stall <= rx_hold || (rx_gap > 0);
	end

	task automatic write_reg(pcd_pkg::cfg_reg_t idx, logic [pcd_pkg::MASK_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		board.set_reg(idx, val);
	endtask

	task automatic apply_settings();
		write_reg(pcd_pkg::REG_MASK_ONE, next_mask[0]);
		write_reg(pcd_pkg::REG_MASK_TWO, next_mask[1]);
		write_reg(pcd_pkg::REG_MASK_THREE, next_mask[2]);
		write_reg(pcd_pkg::REG_MASK_FOUR, next_mask[3]);
		write_reg(pcd_pkg::REG_BLOCKS_ONE, pcd_pkg::MASK_W'(next_blocks[0]));
		write_reg(pcd_pkg::REG_BLOCKS_TWO, pcd_pkg::MASK_W'(next_blocks[1]));
		write_reg(pcd_pkg::REG_BLOCKS_THREE, pcd_pkg::MASK_W'(next_blocks[2]));
		write_reg(pcd_pkg::REG_BLOCKS_FOUR, pcd_pkg::MASK_W'(next_blocks[3]));
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_soft(logic signed [pcd_pkg::DATA_W-1:0] v);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		soft_value <= v;
		do @(posedge clk); while (in_stall);
		board.note_input(v);
	endtask

	task automatic wait_for_outputs();
		in_valid <= 1'b0;
		while (board.outstanding() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic signed [pcd_pkg::DATA_W-1:0] pick_soft();
		case ($urandom_range(0, 7))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			default: return pcd_pkg::DATA_W'($urandom);
		endcase
	endfunction

	// Sparse masks keep frames short enough to reach the tail often.
	function automatic logic [pcd_pkg::MASK_W-1:0] pick_mask();
		logic [pcd_pkg::MASK_W-1:0] m;
		m = '0;
		case ($urandom_range(0, 7))
			0: m = '0;
			1: m = '1;
			2, 3: m = $urandom;
			default: begin
				repeat ($urandom_range(1, 3))
					m[$urandom_range(0, pcd_pkg::MASK_W - 1)] = 1'b1;
			end
		endcase
		return m;
	endfunction

	function automatic logic [pcd_pkg::BLK_W-1:0] pick_blocks();
		case ($urandom_range(0, 15))
			0, 1, 2, 3: return '0;
			4, 5: return pcd_pkg::BLK_W'($urandom_range(2, 3));
			6: return '1;
			default: return pcd_pkg::BLK_W'(1);
		endcase
	endfunction

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = pcd_pkg::REG_MASK_ONE;
		cfg_data = '0;
		in_valid = 1'b0;
		soft_value = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings leave only the tail; run part of it.
		send_soft(16'sh7fff);
		send_soft(16'sh8000);
		send_soft(16'sh0000);
		send_soft(-16'sd1);
		send_soft(16'sh5555);
		send_soft(16'shaaaa);
		wait_for_outputs();

		// New counts while the tail is half done, with a zero-mask segment and
		// a zero-count segment skipped and widely spaced kept positions.
		next_mask[0] = 32'h0000_0001;
		next_mask[1] = 32'h0000_0000;
		next_mask[2] = 32'hffff_ffff;
		next_mask[3] = 32'h8000_0000;
		next_blocks[0] = 10'd1;
		next_blocks[1] = 10'd5;
		next_blocks[2] = 10'd0;
		next_blocks[3] = 10'd1;
		apply_settings();
		for (int i = 0; i < 14; i++)
			send_soft(pick_soft());
		wait_for_outputs();

		for (int ph = 0; ph < 6; ph++) begin
			for (int s = 0; s < pcd_pkg::NUM_SEG; s++) begin
				next_mask[s] = pick_mask();
				next_blocks[s] = pick_blocks();
			end
			if (ph == 0) begin
				for (int s = 0; s < pcd_pkg::NUM_SEG; s++) begin
					next_mask[s] = '1;
					next_blocks[s] = '1;
				end
			end
			tx_quiet = (ph == 1);
			rx_quiet <= (ph == 1);
			apply_settings();
			if (ph == 2) begin
				fork
					begin
						rx_hold <= 1'b1;
						repeat (400) @(posedge clk);
						rx_hold <= 1'b0;
					end
				join_none
			end
			for (int i = 0; i < 20; i++) begin
				if (ph == 3 && i == 10)
					wait_for_outputs();
				send_soft(pick_soft());
			end
			wait_for_outputs();
		end

		repeat (20) @(posedge clk);
		if (board.mismatches == 0) begin
			$display("punctured_code_depuncturer_top regression: pass");
		end else begin
			$display("punctured_code_depuncturer_top regression: fail");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("punctured_code_depuncturer_top regression: fail");
		$finish;
	end
endmodule
